// ===== hw/rtl/nqe_pkg.sv =====
// Shared types and constants for the N-queens enumerator.
package nqe_pkg;

  // Largest board the cell chain is built for.
  localparam int DEF_MAX_SIZE = 8;

  // Board size register.
  localparam int            BS_W     = 4;
  localparam logic [BS_W-1:0] BS_RESET = 4'd8;

  // Result fields.
  localparam int                OUT_COLS  = 8;
  localparam int                OUT_ROW_W = 3;
  localparam int                COUNT_W   = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } nqe_state_t;

  // Search start issued by the controller.
  typedef struct packed {
    logic go;      // start a search step sequence
    logic resume;  // continue past the last solution instead of a fresh board
  } nqe_kick_t;

  // What one cell did in a cycle.
  typedef struct packed {
    logic busy;  // cell holds the search token
    logic fwd;   // placed a queen, token moves right
    logic back;  // no free row left, token moves left
  } nqe_step_t;

endpackage

// ===== hw/rtl/nqe_cell.sv =====
// One column of the search chain: holds its queen row and the attack masks it passes on.
module nqe_cell #(
  parameter int MAX_SIZE = nqe_pkg::DEF_MAX_SIZE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(MAX_SIZE+1)-1:0] n,
  input  logic                          act_fwd,
  input  logic                          act_back,
  input  nqe_pkg::nqe_kick_t            kick,
  input  logic [MAX_SIZE-1:0]           row_in,
  input  logic [MAX_SIZE-1:0]           ld_in,
  input  logic [MAX_SIZE-1:0]           rd_in,
  output logic [MAX_SIZE-1:0]           row_out,
  output logic [MAX_SIZE-1:0]           ld_out,
  output logic [MAX_SIZE-1:0]           rd_out,
  output logic [$clog2(MAX_SIZE)-1:0]   row,
  output nqe_pkg::nqe_step_t            step
);

  localparam int RW = $clog2(MAX_SIZE);
  localparam int NW = $clog2(MAX_SIZE+1);

  logic                active_r;
  logic                resume_r;
  logic [RW-1:0]       row_r;
  logic [MAX_SIZE-1:0] row_out_r;
  logic [MAX_SIZE-1:0] ld_out_r;
  logic [MAX_SIZE-1:0] rd_out_r;

  logic [NW-1:0]       start;
  logic [MAX_SIZE-1:0] cand;
  logic [MAX_SIZE-1:0] pick_oh;
  logic [RW-1:0]       pick;
  logic                hit;
  logic                activate;

  // First row to try: zero when entered from the left, one past the held row on backtrack
  assign start = resume_r ? (NW'(row_r) + NW'(1)) : '0;

  // Free rows within the board at or above the start row
  always_comb begin
    for (int k = 0; k < MAX_SIZE; k++) begin
      cand[k] = !(row_in[k] || ld_in[k] || rd_in[k]) &&
                (NW'(k) >= start) && (NW'(k) < n);
    end
  end

  // Pick the lowest candidate row
  always_comb begin
    pick    = '0;
    pick_oh = '0;
    for (int k = MAX_SIZE - 1; k >= 0; k--) begin
      if (cand[k]) begin
        pick    = RW'(k);
        pick_oh = MAX_SIZE'(1) << k;
      end
    end
  end

  assign hit      = |cand;
  assign activate = act_fwd || act_back || kick.go;

  // Token handling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (activate) begin
      active_r <= 1'b1;
    end else begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (activate) begin
      resume_r <= act_back || kick.resume;
    end
  end

  // Record the placement and the masks handed to the next column
  always_ff @(posedge clk) begin
    if (active_r && hit) begin
      row_r     <= pick;
      row_out_r <= row_in | pick_oh;
      ld_out_r  <= (ld_in | pick_oh) << 1;
      rd_out_r  <= (rd_in | pick_oh) >> 1;
    end
  end

  assign row_out   = row_out_r;
  assign ld_out    = ld_out_r;
  assign rd_out    = rd_out_r;
  assign row       = row_r;
  assign step.busy = active_r;
  assign step.fwd  = active_r && hit;
  assign step.back = active_r && !hit;

endmodule

// ===== hw/rtl/nqe_ctrl.sv =====
// Request sequencer, search bookkeeping and result register.
module nqe_ctrl #(
  parameter int MAX_SIZE = nqe_pkg::DEF_MAX_SIZE
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  in_valid,
  output logic                                                  in_ready,
  input  logic                                                  in_restart,
  input  logic                                                  cfg_wr_en,
  input  logic [nqe_pkg::BS_W-1:0]                              cfg_wr_data,
  output logic                                                  out_valid,
  input  logic                                                  out_ready,
  output logic                                                  out_found,
  output logic [nqe_pkg::OUT_COLS-1:0][nqe_pkg::OUT_ROW_W-1:0]  out_rows,
  output logic [nqe_pkg::COUNT_W-1:0]                           out_solution_count,
  output logic [$clog2(MAX_SIZE+1)-1:0]                         n,
  output nqe_pkg::nqe_kick_t                                    kick,
  output logic                                                  searching,
  input  logic                                                  solved,
  input  logic                                                  exhausted,
  input  logic [nqe_pkg::OUT_COLS-1:0][nqe_pkg::OUT_ROW_W-1:0]  col_rows
);

  localparam int NW = $clog2(MAX_SIZE+1);

  nqe_pkg::nqe_state_t               state_r, state_nxt;
  logic [nqe_pkg::BS_W-1:0]          board_size_r;
  logic                              started_r;
  logic                              exhausted_r;
  logic [nqe_pkg::COUNT_W-1:0]       count_r;
  logic                              found_pend_r;
  logic                              out_valid_r;
  logic                              out_found_r;
  logic [nqe_pkg::OUT_COLS-1:0][nqe_pkg::OUT_ROW_W-1:0] out_rows_r;
  logic [nqe_pkg::COUNT_W-1:0]       out_count_r;

  logic in_acc;
  logic fresh;
  logic load;

  // Effective board size: zero reads as one, oversize clamps to the chain length
  always_comb begin
    if (board_size_r == '0) begin
      n = NW'(1);
    end else if (int'(board_size_r) > MAX_SIZE) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(board_size_r);
    end
  end

  assign in_acc = in_valid && in_ready;
  assign fresh  = in_restart || !started_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nqe_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (fresh || !exhausted_r) ? nqe_pkg::ST_SEARCH : nqe_pkg::ST_HOLD;
        end
      end
      nqe_pkg::ST_SEARCH: begin
        if (solved || exhausted) begin
          state_nxt = nqe_pkg::ST_HOLD;
        end
      end
      nqe_pkg::ST_HOLD: begin
        if (load) begin
          state_nxt = nqe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nqe_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready    = 1'b0;
    searching   = 1'b0;
    load        = 1'b0;
    kick.go     = 1'b0;
    kick.resume = 1'b0;
    unique case (state_r)
      nqe_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        kick.go     = in_acc && (fresh || !exhausted_r);
        kick.resume = !fresh;
      end
      nqe_pkg::ST_SEARCH: begin
        searching = 1'b1;
      end
      nqe_pkg::ST_HOLD: begin
        load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nqe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Board size register; a write forces the next request to start over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= nqe_pkg::BS_RESET;
    end else if (cfg_wr_en) begin
      board_size_r <= cfg_wr_data;
    end
  end

  // Search bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      exhausted_r  <= 1'b0;
      count_r      <= '0;
      found_pend_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        started_r <= 1'b0;
      end else if (in_acc && fresh) begin
        started_r <= 1'b1;
      end
      if (in_acc) begin
        found_pend_r <= 1'b0;
        if (fresh) begin
          exhausted_r <= 1'b0;
          count_r     <= '0;
        end
      end
      if (searching && solved) begin
        found_pend_r <= 1'b1;
        if (count_r != nqe_pkg::COUNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (searching && exhausted) begin
        exhausted_r <= 1'b1;
      end
    end
  end

  // Result register: take the pending result once the previous one is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found_r <= found_pend_r;
      out_count_r <= count_r;
      for (int i = 0; i < nqe_pkg::OUT_COLS; i++) begin
        out_rows_r[i] <= (found_pend_r && (i < int'(n))) ? col_rows[i] : '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_rows           = out_rows_r;
  assign out_solution_count = out_count_r;

endmodule

// ===== hw/rtl/n_queens_solution_enumerator_unit.sv =====
// Operation: each queen placement or backtrack is one search step, then the result is loaded;
// once the search is exhausted, a request skips the search and goes straight to the result.
// Throughput: one request at a time, none taken during a search or before its result is loaded;
// the next request is taken while a result waits.
// Reset: rst_n synchronous, active low; clears the search, result valid and sets
// board_size to 8.
module n_queens_solution_enumerator_unit #(
  parameter int MAX_SIZE = nqe_pkg::DEF_MAX_SIZE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  input  logic                                cfg_wr_en,
  input  logic [nqe_pkg::BS_W-1:0]            cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col0,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col1,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col2,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col3,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col4,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col5,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col6,
  output logic [nqe_pkg::OUT_ROW_W-1:0]       out_row_col7,
  output logic [nqe_pkg::COUNT_W-1:0]         out_solution_count
);

  localparam int RW = $clog2(MAX_SIZE);
  localparam int NW = $clog2(MAX_SIZE+1);

  logic [NW-1:0]                     n;
  nqe_pkg::nqe_kick_t                kick;
  logic                              searching;
  logic                              solved;
  logic                              exhausted;
  logic [MAX_SIZE-1:0]               last;
  logic [MAX_SIZE-1:0]               busy;
  logic [MAX_SIZE-1:0]               done_col;
  nqe_pkg::nqe_step_t                step  [MAX_SIZE];
  logic [MAX_SIZE-1:0][RW-1:0]       cell_row;
  logic [MAX_SIZE:0][MAX_SIZE-1:0]   m_row;
  logic [MAX_SIZE:0][MAX_SIZE-1:0]   m_ld;
  logic [MAX_SIZE:0][MAX_SIZE-1:0]   m_rd;
  logic [nqe_pkg::OUT_COLS-1:0][nqe_pkg::OUT_ROW_W-1:0] col_rows;
  logic [nqe_pkg::OUT_COLS-1:0][nqe_pkg::OUT_ROW_W-1:0] out_rows;

  // Empty board enters the chain at column 0
  assign m_row[0] = '0;
  assign m_ld[0]  = '0;
  assign m_rd[0]  = '0;

  // Column chain
  for (genvar c = 0; c < MAX_SIZE; c++) begin : g_col
    logic               act_fwd;
    logic               act_back;
    nqe_pkg::nqe_kick_t ck;

    assign last[c] = (n == NW'(c + 1));

    if (c == 0) begin : g_first
      assign act_fwd = 1'b0;
    end else begin : g_inner
      assign act_fwd = step[c-1].fwd && !last[c-1];
    end

    if (c == MAX_SIZE - 1) begin : g_end
      assign act_back = 1'b0;
    end else begin : g_mid
      assign act_back = step[c+1].back;
    end

    // Fresh search starts at column 0, resume re-enters at the last column
    assign ck.go     = kick.go && (kick.resume ? last[c] : (c == 0));
    assign ck.resume = kick.resume;

    nqe_cell #(
      .MAX_SIZE (MAX_SIZE)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .n        (n),
      .act_fwd  (act_fwd),
      .act_back (act_back),
      .kick     (ck),
      .row_in   (m_row[c]),
      .ld_in    (m_ld[c]),
      .rd_in    (m_rd[c]),
      .row_out  (m_row[c+1]),
      .ld_out   (m_ld[c+1]),
      .rd_out   (m_rd[c+1]),
      .row      (cell_row[c]),
      .step     (step[c])
    );

    assign busy[c]     = step[c].busy;
    assign done_col[c] = step[c].fwd && last[c];
  end

  assign solved    = |done_col;
  assign exhausted = step[0].back;

  // Rows seen by the result fields
  for (genvar i = 0; i < nqe_pkg::OUT_COLS; i++) begin : g_out
    if (i < MAX_SIZE) begin : g_used
      assign col_rows[i] = nqe_pkg::OUT_ROW_W'(cell_row[i]);
    end else begin : g_unused
      assign col_rows[i] = '0;
    end
  end

  nqe_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_rows           (out_rows),
    .out_solution_count (out_solution_count),
    .n                  (n),
    .kick               (kick),
    .searching          (searching),
    .solved             (solved),
    .exhausted          (exhausted),
    .col_rows           (col_rows)
  );

  assign out_row_col0 = out_rows[0];
  assign out_row_col1 = out_rows[1];
  assign out_row_col2 = out_rows[2];
  assign out_row_col3 = out_rows[3];
  assign out_row_col4 = out_rows[4];
  assign out_row_col5 = out_rows[5];
  assign out_row_col6 = out_rows[6];
  assign out_row_col7 = out_rows[7];

`ifndef SYNTH
  // Only one column holds the search token
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(busy))
    else $error("more than one cell active");

  // A column works only while the controller is searching
  a_busy_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (|busy) |-> searching)
    else $error("cell active outside search");

  // A search step ends in a solution or exhaustion, never both
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    !(solved && exhausted))
    else $error("solution and exhaustion together");

  // A delivered solution is always counted
  a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_solution_count != '0))
    else $error("solution given with zero count");
`endif

endmodule

// ===== test/n_queens_solution_enumerator_unit_tb.sv =====
// Testbench for the N-queens enumerator: random handshakes, a search predictor, per-field checks.
`timescale 1ns / 1ps

module n_queens_solution_enumerator_unit_tb;

  localparam int QMAX = nqe_pkg::DEF_MAX_SIZE;
  localparam int DIAGS = 2 * QMAX - 1;

  typedef struct packed {
    logic                                                 found;
    logic [nqe_pkg::OUT_COLS-1:0][nqe_pkg::OUT_ROW_W-1:0] rows;
    logic [nqe_pkg::COUNT_W-1:0]                          count;
  } board_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [nqe_pkg::BS_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [nqe_pkg::OUT_ROW_W-1:0] out_row_col0, out_row_col1, out_row_col2, out_row_col3;
  logic [nqe_pkg::OUT_ROW_W-1:0] out_row_col4, out_row_col5, out_row_col6, out_row_col7;
  logic [nqe_pkg::COUNT_W-1:0] out_solution_count;

  // Stimulus and expectation stores
  bit            pending_restarts[$];
  board_result_t expected_boards[$];

  // Predictor copy of the search state
  logic [nqe_pkg::OUT_ROW_W-1:0] queen_at[QMAX];
  int unsigned                   cols_placed;
  logic [QMAX-1:0]               rows_used;
  logic [DIAGS-1:0]              rise_used;
  logic [DIAGS-1:0]              fall_used;
  bit                            search_live;
  bit                            search_done;
  int unsigned                   given_count;
  logic [nqe_pkg::BS_W-1:0]      size_reg;

  // Bookkeeping
  bit calm_phase;
  int send_gap;
  int hold_left;
  int mismatches;
  int requests_sent;
  int restarts_sent;
  int results_seen;
  int solutions_seen;
  int exhausted_seen;
  int size_writes;

  n_queens_solution_enumerator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_row_col0       (out_row_col0),
    .out_row_col1       (out_row_col1),
    .out_row_col2       (out_row_col2),
    .out_row_col3       (out_row_col3),
    .out_row_col4       (out_row_col4),
    .out_row_col5       (out_row_col5),
    .out_row_col6       (out_row_col6),
    .out_row_col7       (out_row_col7),
    .out_solution_count (out_solution_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Set or clear the row and both diagonals of one queen
  function automatic void mark_queen(int r, int c, bit set);
    rows_used[r] = set;
    rise_used[r + c] = set;
    fall_used[r + QMAX - 1 - c] = set;
  endfunction

  function automatic bit square_free(int r, int c);
    return !rows_used[r] && !rise_used[r + c] && !fall_used[r + QMAX - 1 - c];
  endfunction

  // Walk the depth-first search to the next full placement; 0 when none is left
  function automatic bit walk_to_next(int n, bit fresh);
    int c;
    int r;
    int start;
    bit done;
    bit hit;
    done = 1'b0;
    hit = 1'b0;
    if (fresh || cols_placed == 0 || cols_placed > n) begin
      rows_used = '0;
      rise_used = '0;
      fall_used = '0;
      c = 0;
      start = 0;
    end else begin
      c = cols_placed - 1;
      mark_queen(int'(queen_at[c]), c, 1'b0);
      start = int'(queen_at[c]) + 1;
    end
    while (!done) begin
      r = start;
      while (r < n && !square_free(r, c)) r++;
      if (r < n) begin
        queen_at[c] = r[nqe_pkg::OUT_ROW_W-1:0];
        mark_queen(r, c, 1'b1);
        c++;
        start = 0;
        if (c == n) begin
          cols_placed = c;
          hit = 1'b1;
          done = 1'b1;
        end
      end else if (c == 0) begin
        cols_placed = 0;
        done = 1'b1;
      end else begin
        c--;
        mark_queen(int'(queen_at[c]), c, 1'b0);
        start = int'(queen_at[c]) + 1;
      end
    end
    return hit;
  endfunction

  // Work out the board answered for one request
  function automatic board_result_t predict_board(bit restart);
    board_result_t res;
    int n;
    bit fresh;
    n = (size_reg == 0) ? 1 : (size_reg > QMAX) ? QMAX : int'(size_reg);
    fresh = 1'b0;
    if (restart || !search_live) begin
      search_live = 1'b1;
      search_done = 1'b0;
      given_count = 0;
      cols_placed = 0;
      fresh = 1'b1;
    end
    res = '0;
    if (!search_done) begin
      if (walk_to_next(n, fresh)) begin
        if (given_count < nqe_pkg::COUNT_MAX) given_count++;
        res.found = 1'b1;
        for (int i = 0; i < n && i < nqe_pkg::OUT_COLS; i++) res.rows[i] = queen_at[i];
      end else begin
        search_done = 1'b1;
      end
    end
    res.count = given_count[nqe_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one, none in a calm phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Drive requests and predict each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_boards.push_back(predict_board(in_restart));
        requests_sent++;
        if (in_restart) restarts_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_restarts.size() > 0) begin
          in_valid <= 1'b1;
          in_restart <= pending_restarts.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transaction against the oldest expectation, stall at random
  always @(posedge clk) begin
    board_result_t got;
    board_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.found = out_found;
        got.rows = {out_row_col7, out_row_col6, out_row_col5, out_row_col4,
                    out_row_col3, out_row_col2, out_row_col1, out_row_col0};
        got.count = out_solution_count;
        results_seen++;
        if (expected_boards.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(got.count), 32'hffff_ffff);
        end else begin
          want = expected_boards.pop_front();
          if (got.found === 1'b1) solutions_seen++;
          else exhausted_seen++;
          if (got.found !== want.found) report_mismatch("found", 32'(got.found), 32'(want.found));
          for (int i = 0; i < nqe_pkg::OUT_COLS; i++)
            if (got.rows[i] !== want.rows[i])
              report_mismatch($sformatf("row_col%0d", i), 32'(got.rows[i]), 32'(want.rows[i]));
          if (got.count !== want.count)
            report_mismatch("solution_count", 32'(got.count), 32'(want.count));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        hold_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Wait until every request is answered, then let the block drain
  task automatic settle();
    do @(negedge clk);
    while (pending_restarts.size() != 0 || in_valid || expected_boards.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write board_size while idle and mirror it in the predictor
  task automatic write_size(logic [nqe_pkg::BS_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_reg = value;
    search_live = 1'b0;
    size_writes++;
    @(negedge clk);
  endtask

  // Limit on the whole run
  initial begin
    #40_000_000;
    $display("timeout: %0d requests queued, %0d results outstanding",
             pending_restarts.size(), expected_boards.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    int eff;
    int len;
    int pick;
    int random_items;
    logic [nqe_pkg::BS_W-1:0] sz;

    size_reg = nqe_pkg::BS_RESET;
    search_live = 1'b0;
    search_done = 1'b0;
    given_count = 0;
    cols_placed = 0;
    rows_used = '0;
    rise_used = '0;
    fall_used = '0;
    for (int i = 0; i < QMAX; i++) queen_at[i] = '0;
    calm_phase = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size: resume before any start acts as a restart
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    settle();

    // Four queens: both solutions, then exhausted answers, then a restart
    write_size(4'd4);
    pending_restarts.push_back(1'b1);
    repeat (4) pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    settle();

    // No solution exists on a board of three
    write_size(4'd3);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    settle();

    // Size zero is taken as one; the write forces a fresh search
    write_size(4'd0);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b0);
    settle();

    // Oversize is clamped to the largest board
    write_size(4'd15);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    settle();

    write_size(4'd2);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    settle();

    // Rewriting the size between requests drops the search in progress
    write_size(4'd6);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    settle();
    write_size(4'd6);
    pending_restarts.push_back(1'b0);
    settle();

    // Walk the whole eight-queens enumeration past its end
    write_size(4'd8);
    calm_phase = ($urandom_range(0, 1) == 0);
    pending_restarts.push_back(1'(($urandom_range(0, 1))));
    repeat (96) pending_restarts.push_back(1'b0);
    random_items = 97;
    settle();

    // Random phases: mostly long resume runs with a rare restart
    while (random_items < 450) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) sz = 4'($urandom_range(0, 3));
      else if (pick == 2) sz = 4'($urandom_range(9, 15));
      else sz = 4'($urandom_range(4, 8));
      eff = (sz == 0) ? 1 : (sz > QMAX) ? QMAX : int'(sz);
      len = (eff >= 5) ? $urandom_range(10, 50) : $urandom_range(3, 12);
      write_size(sz);
      calm_phase = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        if (k == 0) pending_restarts.push_back(1'($urandom_range(0, 1)));
        else pending_restarts.push_back($urandom_range(0, 15) == 0);
      end
      random_items += len;
      settle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d requests (%0d restarts) over %0d board_size writes",
             requests_sent, restarts_sent, size_writes);
    $display("saw %0d solutions and %0d exhausted answers in %0d results, %0d mismatches",
             solutions_seen, exhausted_seen, results_seen, mismatches);
    if (mismatches == 0 && expected_boards.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
